// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the canceller modules
// Each macro expands to one labeled concurrent assertion that reports by $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define NRC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define NRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/nrc_pkg.sv =====
// ----------------------------------------------------------------------------
// NLMS reference canceller package
// Shared widths, constants, register indexes and controller types.
// ----------------------------------------------------------------------------
package nrc_pkg;

    // Default sizes.
    localparam int TAPS_DEF   = 128;
    localparam int MAX_CH_DEF = 8;

    // Field widths.
    localparam int SAMPLE_W   = 16;
    localparam int CH_W       = 3;
    localparam int VAD_W      = 8;
    localparam int GAIN_W     = 11;
    localparam int RATE_W     = 14;
    localparam int COUNT_W    = 4;
    localparam int WEIGHT_W   = 24;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Register indexes of the configuration channel.
    localparam logic [CFG_IDX_W-1:0] CFG_REF_EN  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHCOUNT = 4'd3;

    // Register reset values.
    localparam int GAIN_RESET  = 666;
    localparam int RATE_RESET  = 2621;
    localparam int COUNT_RESET = 2;

    // Arithmetic constants.
    localparam int NORM_BIAS         = 1074;     // 1e-6 in Q2.30
    localparam int WEIGHT_LIMIT      = 4194304;  // 2.0 in Q2.21
    localparam int STEP_LIMIT_SHIFT  = 40;
    localparam int GAIN_BYPASS_MAX   = 1;
    localparam int VAD_ADAPT_LIMIT   = 64;       // 0.25 in Q0.8
    localparam int ERR_SCALE_SHIFT   = 6;        // Q.15 to Q.21
    localparam int EST_ERR_SHIFT     = 15;       // Q.36 to Q.21
    localparam int GAIN_SHIFT        = 31;       // Q.46 to Q.15
    localparam int STEP_SCALE_SHIFT  = 15;
    localparam int UPD_SHIFT         = 16;       // Q.37 to Q.21

    // Controller states.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_HIST_WR,
        S_EST_RUN,
        S_EST_DRAIN,
        S_CALC1,
        S_CALC2,
        S_DIV_START,
        S_DIV_WAIT,
        S_UPD_RUN,
        S_UPD_DRAIN,
        S_FINISH,
        S_EMIT
    } t_ctrl_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic clear;
        logic hist_wr;
        logic est_run;
        logic upd_run;
        logic calc1;
        logic calc2;
        logic div_start;
        logic finish;
        logic emit;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic toggle;
        logic clear_done;
        logic in_valid;
        logic active;
        logic ch_zero;
        logic adapt;
        logic last_tap;
        logic pipe_empty;
        logic div_done;
        logic out_free;
    } t_ctrl_status;

endpackage

// ===== src/nrc_if.sv =====
// ----------------------------------------------------------------------------
// NLMS reference canceller channel interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface nrc_in_if;
    import nrc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] reference_sample;
    logic signed [SAMPLE_W-1:0] primary_sample;
    logic [CH_W-1:0]            channel;
    logic                       segment_quiet;
    logic [VAD_W-1:0]           previous_vad;

    modport source (output valid, reference_sample, primary_sample, channel,
                    segment_quiet, previous_vad, input ready);
    modport sink (input valid, reference_sample, primary_sample, channel,
                  segment_quiet, previous_vad, output ready);
endinterface

interface nrc_out_if;
    import nrc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] cleaned_sample;
    logic [CH_W-1:0]            out_channel;

    modport source (output valid, cleaned_sample, out_channel, input ready);
    modport sink (input valid, cleaned_sample, out_channel, output ready);
endinterface

interface nrc_cfg_if;
    import nrc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/nrc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nrc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/nrc_divider.sv =====
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned division, one quotient bit per cycle, NUM_W quotient bits per division.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nrc_divider #(
    parameter int NUM_W = 62,
    parameter int DEN_W = 39
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo,
    output logic             o_done
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_nx;
    logic             fits;

    // One trial subtraction per cycle.
    always_comb begin
        rem_sh = {r_rem, r_quo[NUM_W-1]};
        fits   = rem_sh >= {1'b0, r_den};
        rem_nx = fits ? (rem_sh - {1'b0, r_den}) : rem_sh;
    end

    // Control of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= rem_nx[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], fits};
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

    `NRC_ASSERT(a_div_start_idle, i_clk, i_rst_n, i_start |-> !r_busy, "divider restarted while busy")
    `NRC_ASSERT(a_div_done_end, i_clk, i_rst_n, o_done |-> !r_busy && $past(r_busy), "stray done")
endmodule

// ===== src/nrc_datapath.sv =====
// ----------------------------------------------------------------------------
// NLMS reference canceller datapath
// Configuration registers, history and weight memories, the tap pipeline,
// the output arithmetic, the step divider and the result register.
// ----------------------------------------------------------------------------
module nrc_datapath #(
    parameter int TAPS         = nrc_pkg::TAPS_DEF,
    parameter int MAX_CHANNELS = nrc_pkg::MAX_CH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    nrc_in_if.sink               i_in,
    nrc_out_if.source            o_out,
    nrc_cfg_if.sink              i_cfg,
    input  nrc_pkg::t_ctrl_cmd   i_cmd,
    output nrc_pkg::t_ctrl_status o_status
);
    import nrc_pkg::*;

    localparam int POS_W   = $clog2(TAPS);
    localparam int WDEPTH  = MAX_CHANNELS * TAPS;
    localparam int WADDR_W = $clog2(WDEPTH);
    localparam int PROD_W  = WEIGHT_W + SAMPLE_W;
    localparam int EST_W   = PROD_W + $clog2(TAPS);
    localparam int HSQ_W   = 2 * SAMPLE_W;
    localparam int NORM_W  = HSQ_W + $clog2(TAPS);
    localparam int GP_W    = EST_W + GAIN_W + 1;
    localparam int Y_W     = GP_W - GAIN_SHIFT + 1;
    localparam int ERR_W   = EST_W - EST_ERR_SHIFT + 2;
    localparam int NUMP_W  = RATE_W + 1 + ERR_W;
    localparam int NUM_W   = NUMP_W - 1 + STEP_SCALE_SHIFT;
    localparam int STEP_W  = STEP_LIMIT_SHIFT + 2;
    localparam int UPROD_W = STEP_W + SAMPLE_W;
    localparam int UPD_W   = UPROD_W - UPD_SHIFT;
    localparam int NW_W    = UPD_W + 1;

    localparam logic signed [EST_W-1:0]   EST_HALF = EST_W'(1) <<< (EST_ERR_SHIFT - 1);
    localparam logic signed [GP_W-1:0]    GP_HALF  = GP_W'(1) <<< (GAIN_SHIFT - 1);
    localparam logic signed [UPROD_W-1:0] UPD_HALF = UPROD_W'(1) <<< (UPD_SHIFT - 1);
    localparam logic signed [Y_W-1:0]     Y_HI     = Y_W'(2 ** (SAMPLE_W - 1) - 1);
    localparam logic signed [Y_W-1:0]     Y_LO     = -Y_HI - Y_W'(1);
    localparam logic signed [NW_W-1:0]    W_HI     = NW_W'(WEIGHT_LIMIT);
    localparam logic signed [NW_W-1:0]    W_LO     = -W_HI;
    localparam logic [NUM_W-1:0]          STEP_CAP = NUM_W'(1) << STEP_LIMIT_SHIFT;

    // Configuration registers.
    logic              r_ref_en;
    logic [GAIN_W-1:0] r_gain;
    logic [RATE_W-1:0] r_rate;
    logic [COUNT_W-1:0] r_count;
    logic              toggle;

    // Captured item.
    logic signed [SAMPLE_W-1:0] r_ref;
    logic signed [SAMPLE_W-1:0] r_prim;
    logic [CH_W-1:0]            r_ch;
    logic                       r_quiet;
    logic [VAD_W-1:0]           r_vad;
    logic [WADDR_W-1:0]         r_wbase;
    logic                       in_fire;

    // Filter state and tap sequencing.
    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   r_tap;
    logic [POS_W-1:0]   r_hidx;
    logic [WADDR_W-1:0] r_clr;
    logic               clear_done;
    logic               clr_in_hist;
    logic               run;
    logic [COUNT_W-1:0] count_eff;
    logic               last_ch;

    // Memory ports.
    logic               hist_we;
    logic [POS_W-1:0]   hist_waddr;
    logic [SAMPLE_W-1:0] hist_wdata;
    logic [SAMPLE_W-1:0] h_q;
    logic               wt_we;
    logic [WADDR_W-1:0] wt_waddr;
    logic [WEIGHT_W-1:0] wt_wdata;
    logic [WADDR_W-1:0] wt_raddr;
    logic [WEIGHT_W-1:0] w_q;

    // Tap pipeline.
    logic                       r_s1;
    logic                       r_s1_upd;
    logic [WADDR_W-1:0]         r_s1_waddr;
    logic                       r_s2;
    logic                       r_s2_upd;
    logic [WADDR_W-1:0]         r_s2_waddr;
    logic signed [WEIGHT_W-1:0] r_s2_w;
    logic signed [PROD_W-1:0]   r_prod;
    logic [HSQ_W-1:0]           r_hsq;
    logic signed [HSQ_W-1:0]    hsq;
    logic signed [UPROD_W-1:0]  r_uprod;
    logic signed [UPROD_W-1:0]  upd_sum;
    logic signed [UPD_W-1:0]    upd_inc;
    logic signed [NW_W-1:0]     nw;
    logic signed [NW_W-1:0]     nw_clamp;

    // Output arithmetic and step.
    logic signed [EST_W-1:0]    r_est;
    logic [NORM_W-1:0]          r_norm;
    logic signed [EST_W-1:0]    est_sum;
    logic signed [ERR_W-1:0]    err;
    logic signed [ERR_W-1:0]    r_err;
    logic signed [GP_W-1:0]     r_gp;
    logic signed [GP_W-1:0]     gp_sum;
    logic signed [Y_W-1:0]      y_full;
    logic signed [SAMPLE_W-1:0] r_result;
    logic signed [NUMP_W-1:0]   r_nump;
    logic [NUMP_W-1:0]          nump_abs;
    logic [NUM_W-1:0]           div_num;
    logic [NUM_W-1:0]           div_quo;
    logic                       div_done;
    logic [STEP_W-1:0]          step_mag;
    logic signed [STEP_W-1:0]   r_step;

    // Result register.
    logic                       r_ov;
    logic signed [SAMPLE_W-1:0] r_os;
    logic [CH_W-1:0]            r_och;

    // Configuration writes; a change of the enable clears the filter.
    assign i_cfg.ready = 1'b1;
    assign toggle = i_cfg.valid && (i_cfg.index == CFG_REF_EN) && (i_cfg.data[0] != r_ref_en);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_en <= 1'b0;
            r_gain   <= GAIN_W'(GAIN_RESET);
            r_rate   <= RATE_W'(RATE_RESET);
            r_count  <= COUNT_W'(COUNT_RESET);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_REF_EN:  r_ref_en <= i_cfg.data[0];
                CFG_GAIN:    r_gain   <= i_cfg.data[GAIN_W-1:0];
                CFG_RATE:    r_rate   <= i_cfg.data[RATE_W-1:0];
                CFG_CHCOUNT: r_count  <= i_cfg.data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Item capture.
    assign i_in.ready = i_cmd.take;
    assign in_fire    = i_in.valid && i_cmd.take;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ref   <= i_in.reference_sample;
            r_prim  <= i_in.primary_sample;
            r_ch    <= i_in.channel;
            r_quiet <= i_in.segment_quiet;
            r_vad   <= i_in.previous_vad;
            r_wbase <= WADDR_W'(int'(i_in.channel) * TAPS);
        end
    end

    // Effective channel count, clamped to one through MAX_CHANNELS.
    always_comb begin
        if (r_count == '0) begin
            count_eff = COUNT_W'(1);
        end else if (r_count > COUNT_W'(MAX_CHANNELS)) begin
            count_eff = COUNT_W'(MAX_CHANNELS);
        end else begin
            count_eff = r_count;
        end
    end

    assign last_ch = COUNT_W'(r_ch) == (count_eff - COUNT_W'(1));

    // Write position, advanced after the last channel of a frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || toggle) begin
            r_pos <= '0;
        end else if (i_cmd.finish && last_ch) begin
            r_pos <= (r_pos == POS_W'(TAPS - 1)) ? '0 : r_pos + POS_W'(1);
        end
    end

    // Clearing sweep over both memories.
    assign clear_done  = r_clr == WADDR_W'(WDEPTH - 1);
    assign clr_in_hist = {1'b0, r_clr} < (WADDR_W + 1)'(TAPS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || toggle) begin
            r_clr <= '0;
        end else if (i_cmd.clear) begin
            r_clr <= clear_done ? '0 : r_clr + WADDR_W'(1);
        end
    end

    // Tap counters: the history is walked backward from the write position.
    assign run = i_cmd.est_run || i_cmd.upd_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap  <= '0;
            r_hidx <= '0;
        end else if (run) begin
            r_tap  <= r_tap + POS_W'(1);
            r_hidx <= (r_hidx == '0) ? POS_W'(TAPS - 1) : r_hidx - POS_W'(1);
        end else begin
            r_tap  <= '0;
            r_hidx <= r_pos;
        end
    end

    // Memory port selection.
    always_comb begin
        hist_we    = (i_cmd.clear && clr_in_hist) || i_cmd.hist_wr;
        hist_waddr = i_cmd.clear ? r_clr[POS_W-1:0] : r_pos;
        hist_wdata = i_cmd.clear ? '0 : r_ref;
        wt_we      = i_cmd.clear || (r_s2 && r_s2_upd);
        wt_waddr   = i_cmd.clear ? r_clr : r_s2_waddr;
        wt_wdata   = i_cmd.clear ? '0 : WEIGHT_W'(nw_clamp);
        wt_raddr   = r_wbase + WADDR_W'(r_tap);
    end

    nrc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TAPS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_re    (run),
        .i_raddr (r_hidx),
        .o_rdata (h_q)
    );

    nrc_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (WDEPTH)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (wt_we),
        .i_waddr (wt_waddr),
        .i_wdata (wt_wdata),
        .i_re    (run),
        .i_raddr (wt_raddr),
        .o_rdata (w_q)
    );

    // Pipeline valid flags and update flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1     <= 1'b0;
            r_s1_upd <= 1'b0;
            r_s2     <= 1'b0;
            r_s2_upd <= 1'b0;
        end else begin
            r_s1     <= run;
            r_s1_upd <= i_cmd.upd_run;
            r_s2     <= r_s1;
            r_s2_upd <= r_s1_upd;
        end
    end

    // Product stage: estimate and energy terms, or the weight increment.
    assign hsq = $signed(h_q) * $signed(h_q);

    always_ff @(posedge i_clk) begin
        r_s1_waddr <= wt_raddr;
        r_s2_waddr <= r_s1_waddr;
        if (r_s1) begin
            r_s2_w <= $signed(w_q);
            if (r_s1_upd) begin
                r_uprod <= r_step * $signed(h_q);
            end else begin
                r_prod <= $signed(w_q) * $signed(h_q);
                r_hsq  <= hsq;
            end
        end
    end

    // New weight: rounded increment, then clamp to plus or minus two.
    always_comb begin
        upd_sum = r_uprod + UPD_HALF;
        upd_inc = upd_sum[UPROD_W-1:UPD_SHIFT];
        nw      = NW_W'(r_s2_w) + NW_W'(upd_inc);
        if (nw > W_HI) begin
            nw_clamp = W_HI;
        end else if (nw < W_LO) begin
            nw_clamp = W_LO;
        end else begin
            nw_clamp = nw;
        end
    end

    // Accumulation of estimate and normalization.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_est  <= '0;
            r_norm <= NORM_W'(NORM_BIAS);
        end else if (r_s2 && !r_s2_upd) begin
            r_est  <= r_est + EST_W'(r_prod);
            r_norm <= r_norm + NORM_W'(r_hsq);
        end
    end

    // Error in Q.21 and the scaled estimate.
    always_comb begin
        est_sum = r_est + EST_HALF;
        err     = (ERR_W'(r_prim) <<< ERR_SCALE_SHIFT)
                  - ERR_W'($signed(est_sum[EST_W-1:EST_ERR_SHIFT]));
        gp_sum  = r_gp + GP_HALF;
        y_full  = Y_W'(r_prim) - Y_W'($signed(gp_sum[GP_W-1:GAIN_SHIFT]));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc1) begin
            r_gp  <= r_est * $signed({1'b0, r_gain});
            r_err <= err;
        end
        if (i_cmd.calc2) begin
            r_nump <= $signed({1'b0, r_rate}) * r_err;
        end
    end

    // Result: pass-through by default, saturated difference when active.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_result <= i_in.primary_sample;
        end else if (i_cmd.calc2) begin
            if (y_full > Y_HI) begin
                r_result <= SAMPLE_W'(Y_HI);
            end else if (y_full < Y_LO) begin
                r_result <= SAMPLE_W'(Y_LO);
            end else begin
                r_result <= SAMPLE_W'(y_full);
            end
        end
    end

    // Step size: magnitude division truncates toward zero, then saturate.
    always_comb begin
        nump_abs = r_nump[NUMP_W-1] ? NUMP_W'(-r_nump) : NUMP_W'(r_nump);
        div_num  = {nump_abs[NUMP_W-2:0], {STEP_SCALE_SHIFT{1'b0}}};
        step_mag = (div_quo > STEP_CAP) ? STEP_W'(STEP_CAP) : STEP_W'(div_quo);
    end

    nrc_divider #(
        .NUM_W (NUM_W),
        .DEN_W (NORM_W)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (r_norm),
        .o_quo   (div_quo),
        .o_done  (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (div_done) begin
            r_step <= r_nump[NUMP_W-1] ? -$signed(step_mag) : $signed(step_mag);
        end
    end

    // Result register; a new result loads as the previous one leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_os  <= r_result;
            r_och <= r_ch;
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.cleaned_sample = r_os;
    assign o_out.out_channel    = r_och;

    // Status to the controller.
    always_comb begin
        o_status.toggle     = toggle;
        o_status.clear_done = clear_done;
        o_status.in_valid   = i_in.valid;
        o_status.active     = r_ref_en && (r_gain > GAIN_W'(GAIN_BYPASS_MAX)) && !r_quiet
                              && (COUNT_W'(r_ch) < count_eff);
        o_status.ch_zero    = r_ch == '0;
        o_status.adapt      = r_vad < VAD_W'(VAD_ADAPT_LIMIT);
        o_status.last_tap   = r_tap == POS_W'(TAPS - 1);
        o_status.pipe_empty = !r_s1 && !r_s2;
        o_status.div_done   = div_done;
        o_status.out_free   = !r_ov || o_out.ready;
    end
endmodule

// ===== src/nrc_controller.sv =====
// ----------------------------------------------------------------------------
// NLMS reference canceller controller
// Sequences clearing, the estimate pass, the step division and the update pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nrc_controller (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  nrc_pkg::t_ctrl_status i_status,
    output nrc_pkg::t_ctrl_cmd    o_cmd
);
    import nrc_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        if (i_status.toggle) begin
            n_state = S_CLEAR;
        end else begin
            case (r_state)
                S_CLEAR:     if (i_status.clear_done) n_state = S_IDLE;
                S_IDLE:      if (i_status.in_valid) n_state = S_DECIDE;
                S_DECIDE: begin
                    if (!i_status.active) begin
                        n_state = S_EMIT;
                    end else if (i_status.ch_zero) begin
                        n_state = S_HIST_WR;
                    end else begin
                        n_state = S_EST_RUN;
                    end
                end
                S_HIST_WR:   n_state = S_EST_RUN;
                S_EST_RUN:   if (i_status.last_tap) n_state = S_EST_DRAIN;
                S_EST_DRAIN: if (i_status.pipe_empty) n_state = S_CALC1;
                S_CALC1:     n_state = S_CALC2;
                S_CALC2:     n_state = i_status.adapt ? S_DIV_START : S_FINISH;
                S_DIV_START: n_state = S_DIV_WAIT;
                S_DIV_WAIT:  if (i_status.div_done) n_state = S_UPD_RUN;
                S_UPD_RUN:   if (i_status.last_tap) n_state = S_UPD_DRAIN;
                S_UPD_DRAIN: if (i_status.pipe_empty) n_state = S_FINISH;
                S_FINISH:    n_state = S_EMIT;
                S_EMIT:      if (i_status.out_free) n_state = S_IDLE;
                default:     n_state = S_CLEAR;
            endcase
        end
    end

    // Commands.
    always_comb begin
        o_cmd           = '0;
        o_cmd.take      = (r_state == S_IDLE) && !i_status.toggle;
        o_cmd.clear     = r_state == S_CLEAR;
        o_cmd.hist_wr   = r_state == S_HIST_WR;
        o_cmd.est_run   = r_state == S_EST_RUN;
        o_cmd.upd_run   = r_state == S_UPD_RUN;
        o_cmd.calc1     = r_state == S_CALC1;
        o_cmd.calc2     = r_state == S_CALC2;
        o_cmd.div_start = r_state == S_DIV_START;
        o_cmd.finish    = r_state == S_FINISH;
        o_cmd.emit      = (r_state == S_EMIT) && i_status.out_free;
    end

    `NRC_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> r_state == S_CLEAR, "no clear after reset")
    `NRC_ASSERT(a_toggle_clears, i_clk, i_rst_n, i_status.toggle |=> r_state == S_CLEAR, "enable change not cleared")
    `NRC_ASSERT(a_div_done_wait, i_clk, i_rst_n, i_status.div_done |-> r_state == S_DIV_WAIT, "unexpected quotient")
endmodule

// ===== src/nlms_reference_canceller_core.sv =====
// ----------------------------------------------------------------------------
// NLMS reference canceller core
// Bypassed items go from the decision straight to the result; active items take
// an estimate pass over the memories, and adapting items also take the
// bit-serial step division and a second, update pass over the memories.
// After reset and after any change of the reference enable, a clearing pass
// over the MAX_CHANNELS*TAPS weights runs before the first item is accepted.
// ----------------------------------------------------------------------------
module nlms_reference_canceller_core #(
    parameter int TAPS         = nrc_pkg::TAPS_DEF,
    parameter int MAX_CHANNELS = nrc_pkg::MAX_CH_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    nrc_in_if.sink    i_in,
    nrc_out_if.source o_out,
    nrc_cfg_if.sink   i_cfg
);
    import nrc_pkg::*;

    t_ctrl_cmd    cmd;
    t_ctrl_status status;

    // Sequencer.
    nrc_controller u_controller (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Arithmetic, memories and channel registers.
    nrc_datapath #(
        .TAPS         (TAPS),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_out    (o_out),
        .i_cfg    (i_cfg),
        .i_cmd    (cmd),
        .o_status (status)
    );
endmodule

// ===== tb/nrc_checker.sv =====
// ----------------------------------------------------------------------------
// NLMS reference canceller checker
// Watches the input, result and configuration channels of the canceller,
// predicts every cleaned sample with its own copy of the filter state and
// compares each result transaction with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module nrc_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    nrc_in_if    i_in_mon,
    nrc_out_if   i_out_mon,
    nrc_cfg_if   i_cfg_mon,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import nrc_pkg::*;

    localparam int NTAPS = TAPS_DEF;
    localparam int NCH   = MAX_CH_DEF;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic [CH_W-1:0]            chan;
    } t_clean;

    // Shadow copy of the registers and of the filter state.
    logic                       ref_en;
    logic [GAIN_W-1:0]          gain;
    logic [RATE_W-1:0]          rate;
    logic [COUNT_W-1:0]         chan_count;
    logic signed [SAMPLE_W-1:0] ref_hist [NTAPS];
    logic signed [WEIGHT_W-1:0] weights [NCH*NTAPS];
    int                         wr_pos;

    t_clean expected_clean [$];
    int     fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_clean.size();

    // Floor of (v + half) / 2^s.
    function automatic longint round_half_up(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic clear_filter();
        foreach (ref_hist[i]) ref_hist[i] = '0;
        foreach (weights[i]) weights[i] = '0;
        wr_pos = 0;
    endtask

    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_REF_EN: begin
                if (data[0] != ref_en) clear_filter();
                ref_en = data[0];
            end
            CFG_GAIN:    gain = data[GAIN_W-1:0];
            CFG_RATE:    rate = data[RATE_W-1:0];
            CFG_CHCOUNT: chan_count = data[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    // Computes the cleaned sample of one input transaction and updates the state.
    task automatic predict_clean(input logic signed [SAMPLE_W-1:0] refs,
                                 input logic signed [SAMPLE_W-1:0] prim,
                                 input logic [CH_W-1:0] chan,
                                 input logic quiet,
                                 input logic [VAD_W-1:0] vad);
        t_clean r;
        longint est, nrm, y, err, step, h, nw;
        int     cnt, pos, idx, base;
        r.sample = prim;
        r.chan   = chan;
        cnt = (chan_count < 1) ? 1 : ((chan_count > NCH) ? NCH : int'(chan_count));
        if (ref_en && gain > GAIN_BYPASS_MAX && !quiet && chan < cnt) begin
            pos  = wr_pos;
            base = chan * NTAPS;
            if (chan == 0) ref_hist[pos] = refs;
            // Estimate and reference energy over the history.
            est = 0;
            nrm = NORM_BIAS;
            idx = pos;
            for (int t = 0; t < NTAPS; t++) begin
                h = ref_hist[idx];
                est += longint'(weights[base+t]) * h;
                nrm += h * h;
                idx = (idx == 0) ? NTAPS - 1 : idx - 1;
            end
            y = longint'(prim) - round_half_up(est * longint'(gain), GAIN_SHIFT);
            if (y > 32767) y = 32767;
            if (y < -32768) y = -32768;
            r.sample = y[SAMPLE_W-1:0];
            // Normalized weight update when the previous segment was quiet enough.
            if (vad < VAD_ADAPT_LIMIT) begin
                err  = longint'(prim) * 64 - round_half_up(est, EST_ERR_SHIFT);
                step = (longint'(rate) * err * 32768) / nrm;
                if (step > (longint'(1) <<< STEP_LIMIT_SHIFT))
                    step = longint'(1) <<< STEP_LIMIT_SHIFT;
                if (step < -(longint'(1) <<< STEP_LIMIT_SHIFT))
                    step = -(longint'(1) <<< STEP_LIMIT_SHIFT);
                idx = pos;
                for (int t = 0; t < NTAPS; t++) begin
                    h  = ref_hist[idx];
                    nw = longint'(weights[base+t]) + round_half_up(step * h, UPD_SHIFT);
                    if (nw > WEIGHT_LIMIT) nw = WEIGHT_LIMIT;
                    if (nw < -WEIGHT_LIMIT) nw = -WEIGHT_LIMIT;
                    weights[base+t] = nw[WEIGHT_W-1:0];
                    idx = (idx == 0) ? NTAPS - 1 : idx - 1;
                end
            end
            if (chan == cnt - 1) wr_pos = (pos + 1) % NTAPS;
        end
        expected_clean.push_back(r);
    endtask

    // Observe every transaction on the three channels.
    always @(posedge i_clk) begin
        t_clean want;
        if (!i_rst_n) begin
            ref_en     = 1'b0;
            gain       = GAIN_W'(GAIN_RESET);
            rate       = RATE_W'(RATE_RESET);
            chan_count = COUNT_W'(COUNT_RESET);
            clear_filter();
            expected_clean.delete();
            fail_count = 0;
        end else begin
            if (i_cfg_mon.valid && i_cfg_mon.ready)
                apply_register(i_cfg_mon.index, i_cfg_mon.data);
            if (i_in_mon.valid && i_in_mon.ready)
                predict_clean(i_in_mon.reference_sample, i_in_mon.primary_sample,
                              i_in_mon.channel, i_in_mon.segment_quiet,
                              i_in_mon.previous_vad);
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_clean.size() == 0) begin
                    report_mismatch("unexpected result", i_out_mon.cleaned_sample, 0);
                end else begin
                    want = expected_clean.pop_front();
                    if (i_out_mon.cleaned_sample !== want.sample)
                        report_mismatch("cleaned_sample", i_out_mon.cleaned_sample,
                                        want.sample);
                    if (i_out_mon.out_channel !== want.chan)
                        report_mismatch("out_channel", i_out_mon.out_channel, want.chan);
                end
            end
        end
    end
endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// NLMS reference canceller testbench
// Drives directed and random sample frames and register writes into the
// canceller with random idle bursts on both sides; the checker predicts and
// compares every result, and this module reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import nrc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 400;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   idle_on;
    int   stall_left;
    int   quiet_cycles;
    logic [COUNT_W-1:0] frame_chans;

    nrc_in_if  in_ch();
    nrc_out_if out_ch();
    nrc_cfg_if cfg_ch();

    nlms_reference_canceller_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    nrc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .i_cfg_mon    (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock.
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Result side back-pressure in random bursts.
    always @(negedge i_clk) begin
        if (idle_on && stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            out_ch.ready <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 5);
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One sample transaction, with an optional idle burst before it.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] refs,
                               input logic signed [SAMPLE_W-1:0] prim,
                               input logic [CH_W-1:0] chan,
                               input logic quiet,
                               input logic [VAD_W-1:0] vad);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        in_ch.reference_sample = refs;
        in_ch.primary_sample   = prim;
        in_ch.channel          = chan;
        in_ch.segment_quiet    = quiet;
        in_ch.previous_vad     = vad;
        in_ch.valid            = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    // Register write, issued only once the block has drained.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        cfg_ch.valid = 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // A run of frames, mostly well formed, with correlated primary samples.
    task automatic send_frames(input int items, input int chans);
        logic signed [SAMPLE_W-1:0] refs, prim;
        int   sent, kind;
        sent = 0;
        while (sent < items) begin
            refs = 16'($urandom);
            for (int c = 0; c < chans && sent < items; c++) begin
                kind = $urandom_range(0, 19);
                prim = (kind < 14) ? (refs >>> $urandom_range(0, 3)) + $signed(16'($urandom_range(0, 255)) - 16'sd128)
                                   : 16'($urandom);
                send_sample(refs, prim,
                            (kind == 19) ? 3'($urandom) : 3'(c),
                            (kind == 18),
                            (kind < 15) ? 8'($urandom_range(0, 63)) : 8'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        int chans;
        idle_on      = 1'b1;
        stall_left   = 0;
        quiet_cycles = 0;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.reference_sample = '0;
        in_ch.primary_sample   = '0;
        in_ch.channel          = '0;
        in_ch.segment_quiet    = 1'b0;
        in_ch.previous_vad     = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        out_ch.ready = 1'b1;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reference detached: samples pass through.
        send_sample(16'sh7FFF, -16'sd32768, 3'd0, 1'b0, 8'd0);
        send_sample(-16'sd32768, 16'sh7FFF, 3'd1, 1'b0, 8'd0);

        // Reference attached at full gain and fastest rate.
        write_register(CFG_REF_EN, 16'd1);
        write_register(CFG_GAIN, 16'd1024);
        write_register(CFG_RATE, 16'd13107);
        write_register(CFG_CHCOUNT, 16'd2);
        send_sample(16'sh7FFF, 16'sh7FFF, 3'd0, 1'b0, 8'd0);
        send_sample(16'sh7FFF, -16'sd32768, 3'd1, 1'b0, 8'd63);
        send_sample(-16'sd32768, -16'sd32768, 3'd0, 1'b0, 8'd0);
        send_sample(-16'sd32768, 16'sh7FFF, 3'd1, 1'b0, 8'd64);
        send_sample(16'sh7FFF, 16'sd0, 3'd0, 1'b0, 8'd255);
        send_sample(16'sh1234, 16'sh4321, 3'd5, 1'b0, 8'd0);
        send_sample(16'sh1234, 16'sh4321, 3'd1, 1'b1, 8'd0);
        send_sample(-16'sd1, 16'sh5555, 3'd1, 1'b0, 8'd1);
        // Gain of one LSB or zero bypasses.
        write_register(CFG_GAIN, 16'd1);
        send_sample(16'sh7FFF, 16'sd100, 3'd0, 1'b0, 8'd0);
        write_register(CFG_GAIN, 16'd0);
        send_sample(16'sh7FFF, 16'sd100, 3'd0, 1'b0, 8'd0);
        // Unknown register index and the channel count extremes.
        write_register(4'd9, 16'hFFFF);
        write_register(CFG_GAIN, 16'd1024);
        write_register(CFG_RATE, 16'd66);
        write_register(CFG_CHCOUNT, 16'd0);
        send_sample(16'sh4000, 16'sh2000, 3'd0, 1'b0, 8'd0);
        send_sample(16'sh4000, 16'sh2000, 3'd1, 1'b0, 8'd0);
        write_register(CFG_CHCOUNT, 16'd15);
        for (int c = 0; c < 8; c++)
            send_sample(16'sh3000, 16'($urandom), 3'(c), 1'b0, 8'd10);

        // Random phases, each with its own register setting.
        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 11) idle_on = 1'b0;
            if ($urandom_range(0, 3) == 0) write_register(CFG_REF_EN, 16'($urandom));
            else write_register(CFG_REF_EN, 16'd1);
            case ($urandom_range(0, 4))
                0: write_register(CFG_GAIN, 16'($urandom));
                1: write_register(CFG_GAIN, 16'd1024);
                default: write_register(CFG_GAIN, 16'($urandom_range(2, 1024)));
            endcase
            case ($urandom_range(0, 4))
                0: write_register(CFG_RATE, 16'($urandom));
                1: write_register(CFG_RATE, 16'd13107);
                2: write_register(CFG_RATE, 16'd66);
                default: write_register(CFG_RATE, 16'($urandom_range(66, 13107)));
            endcase
            frame_chans = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
            write_register(CFG_CHCOUNT, {12'($urandom), frame_chans});
            chans = (frame_chans < 1) ? 1 : ((frame_chans > 8) ? 8 : int'(frame_chans));
            send_frames(150, chans);
        end

        // Drain.
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ===== nlms_reference_canceller_core.f =====
+incdir+src
src/nrc_pkg.sv
src/nrc_if.sv
src/nrc_ram.sv
src/nrc_divider.sv
src/nrc_datapath.sv
src/nrc_controller.sv
src/nlms_reference_canceller_core.sv
tb/nrc_checker.sv
tb/testbench.sv
